// ----- rtl/servo_move_record_playback_defines.svh -----
// ----------------------------------------------------------------------------
// Servo move record/playback assertion macros
// Shared concurrent assertion forms for the sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef SERVO_MOVE_RECORD_PLAYBACK_DEFINES_SVH
`define SERVO_MOVE_RECORD_PLAYBACK_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SMRP_ASSERT_NOW(label, ante, cons, msg) \
label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
   else $error(msg);

// Next-cycle implication, checked outside reset.
`define SMRP_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
   else $error(msg);

`endif

// ----- rtl/smrp_pkg.sv -----
// ----------------------------------------------------------------------------
// Servo move record/playback package
// Types, widths and codes shared by the sequencer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smrp_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int CMD_W    = 3;
   localparam int EVENT_W  = 3;
   localparam int ID_W     = 8;
   localparam int POS_W    = 12;
   localparam int TICKS_W  = 16;
   localparam int COUNT_W  = 7;
   localparam int MARGIN_W = 10;
   localparam int WAIT_W   = 17;
   localparam int ENTRY_W  = ID_W + POS_W + TICKS_W;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 10;

   localparam logic [ID_W-1:0]     MARKER_RESET = 8'd255;
   localparam logic [MARGIN_W-1:0] MARGIN_RESET = 10'd50;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK      = 3'd0,
      CMD_RECORD    = 3'd1,
      CMD_CLEAR     = 3'd2,
      CMD_START_REC = 3'd3,
      CMD_STOP_REC  = 3'd4,
      CMD_PLAY      = 3'd5
   } cmd_type;

   typedef enum logic [EVENT_W-1:0] {
      EV_NONE      = 3'd0,
      EV_ACCEPT    = 3'd1,
      EV_REJECT    = 3'd2,
      EV_MOVE      = 3'd3,
      EV_RESET_ALL = 3'd4,
      EV_FINISHED  = 3'd5
   } event_type;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_RECORD,
      MODE_PLAY
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MARKER = 1'd0,
      CSR_MARGIN = 1'd1
   } csr_idx_type;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [POS_W-1:0]   pos;
      logic [TICKS_W-1:0] ticks;
   } entry_type;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [ID_W-1:0]    servo_id;
      logic [POS_W-1:0]   target_position;
      logic [TICKS_W-1:0] move_ticks;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]     marker_id;
      logic [MARGIN_W-1:0] margin;
   } cfg_type;

   typedef struct packed {
      logic [EVENT_W-1:0] event_res;
      logic [ID_W-1:0]    servo_id;
      logic [POS_W-1:0]   position;
      logic [TICKS_W-1:0] move_ticks;
      logic [COUNT_W-1:0] stored_count;
      logic               is_recording;
      logic               is_playing;
   } result_type;

endpackage

// ----- rtl/smrp_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data (old data on
// a same-address collision).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smrp_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/smrp_core.sv -----
// ----------------------------------------------------------------------------
// Servo move record/playback core
// Mode, count, pointer and countdown registers, the move table and the
// single-pass decision logic for one transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "servo_move_record_playback_defines.svh"

module smrp_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  smrp_pkg::req_type   req,
   input  smrp_pkg::cfg_type   cfg,
   output smrp_pkg::result_type res
);

   import smrp_pkg::*;

   mode_type           mode_ff, mode_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   pp_ff, pp_in;
   logic [WAIT_W-1:0]  wait_ff, wait_in;
   logic               byp_hit_ff, byp_hit_in;
   entry_type          byp_data_ff;

   logic [ENTRY_W-1:0] rd_data;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ADDR_W-1:0]  wr_addr;
   logic               wr_en;
   entry_type          wr_entry;
   entry_type          entry;
   logic [WAIT_W-1:0]  wait_dec;
   logic [WAIT_W-1:0]  wait_reload;
   event_type          ev;
   logic               issue;
   cmd_type            cmd;

   // The read port always looks at the pointer of the next cycle, so the
   // entry at play_pointer is ready when a tick arrives. A write to that
   // same address in the same cycle is caught by the bypass register.
   smrp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign cmd         = cmd_type'(req.command);
   assign entry       = byp_hit_ff ? byp_data_ff : entry_type'(rd_data);
   assign wait_dec    = (wait_ff != '0) ? wait_ff - WAIT_W'(1) : '0;
   assign wait_reload = WAIT_W'(entry.ticks) + WAIT_W'(cfg.margin);
   assign wr_addr     = count_ff[ADDR_W-1:0];
   assign wr_entry    = '{id: req.servo_id, pos: req.target_position,
                          ticks: req.move_ticks};
   assign rd_addr     = accept ? pp_in[ADDR_W-1:0] : pp_ff[ADDR_W-1:0];
   assign byp_hit_in  = wr_en && (wr_addr == rd_addr);

   // Next state and event.
   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      pp_in    = pp_ff;
      wait_in  = wait_ff;
      wr_en    = 1'b0;
      ev       = EV_NONE;
      issue    = 1'b0;
      case (cmd)
         CMD_TICK: begin
            if (mode_ff == MODE_PLAY) begin
               if (pp_ff >= count_ff) begin
                  mode_in = MODE_IDLE;
                  ev      = EV_FINISHED;
               end else begin
                  wait_in = wait_dec;
                  if (wait_dec == '0) begin
                     issue   = 1'b1;
                     ev      = (entry.id == cfg.marker_id) ? EV_RESET_ALL : EV_MOVE;
                     wait_in = wait_reload;
                     pp_in   = pp_ff + CNT_W'(1);
                  end
               end
            end
         end
         CMD_RECORD: begin
            if (count_ff >= CNT_W'(TABLE_DEPTH)) begin
               ev = EV_REJECT;
            end else begin
               wr_en    = accept;
               count_in = count_ff + CNT_W'(1);
               ev       = EV_ACCEPT;
            end
         end
         CMD_CLEAR: begin
            count_in = '0;
            ev       = EV_ACCEPT;
         end
         CMD_START_REC: begin
            if (mode_ff != MODE_IDLE) begin
               ev = EV_REJECT;
            end else begin
               count_in = '0;
               mode_in  = MODE_RECORD;
               ev       = EV_ACCEPT;
            end
         end
         CMD_STOP_REC: begin
            if (mode_ff != MODE_RECORD) begin
               ev = EV_REJECT;
            end else begin
               mode_in = MODE_IDLE;
               ev      = EV_ACCEPT;
            end
         end
         CMD_PLAY: begin
            if (mode_ff != MODE_IDLE || count_ff == '0) begin
               ev = EV_REJECT;
            end else begin
               mode_in = MODE_PLAY;
               pp_in   = '0;
               wait_in = '0;
               ev      = EV_ACCEPT;
            end
         end
         default: begin
            ev = EV_NONE;
         end
      endcase
   end

   // Result item.
   always_comb begin
      res              = '0;
      res.event_res    = ev;
      res.stored_count = COUNT_W'(count_in);
      res.is_recording = (mode_in == MODE_RECORD);
      res.is_playing   = (mode_in == MODE_PLAY);
      if (issue) begin
         res.servo_id   = entry.id;
         res.move_ticks = entry.ticks;
         res.position   = (ev == EV_MOVE) ? entry.pos : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         count_ff   <= '0;
         pp_ff      <= '0;
         wait_ff    <= '0;
         byp_hit_ff <= 1'b0;
      end else begin
         byp_hit_ff <= byp_hit_in;
         if (accept) begin
            mode_ff  <= mode_in;
            count_ff <= count_in;
            pp_ff    <= pp_in;
            wait_ff  <= wait_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      byp_data_ff <= wr_entry;
   end

   `SMRP_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CNT_W'(TABLE_DEPTH),
      "move count exceeds table depth")
   `SMRP_ASSERT_NOW(a_pointer_bound, 1'b1, pp_ff <= CNT_W'(TABLE_DEPTH),
      "play pointer exceeds table depth")
   `SMRP_ASSERT_NEXT(a_issue_advances, accept && issue,
      pp_ff == $past(pp_ff) + CNT_W'(1), "issued entry did not advance pointer")
   `SMRP_ASSERT_NEXT(a_idle_holds, !accept,
      $stable(count_ff) && $stable(pp_ff) && $stable(wait_ff),
      "state changed without a transaction")

endmodule

// ----- rtl/servo_move_record_playback.sv -----
// ----------------------------------------------------------------------------
// Servo move record/playback sequencer
// Teach-and-playback of servo moves with a result register on the output.
//
//   channel  ports                                   direction  role
//   req      req_valid/ready, command, move fields   in         commands, ticks
//   rsp      rsp_valid/ready, event and status       out        one per request
//   csr      csr_valid/ready, csr_index, csr_data    in         settings write
//
// One request is taken per cycle; its result appears in the output register
// on the next cycle. The move table RAM reads ahead at the next play pointer,
// so the entry is ready when a tick arrives. Reset is synchronous and leaves
// the table contents undefined; no clearing pass is run. A stalled result
// holds the output register and blocks new requests until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module servo_move_record_playback (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [smrp_pkg::CMD_W-1:0]     req_command,
   input  logic [smrp_pkg::ID_W-1:0]      req_servo_id,
   input  logic [smrp_pkg::POS_W-1:0]     req_target_position,
   input  logic [smrp_pkg::TICKS_W-1:0]   req_move_ticks,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [smrp_pkg::EVENT_W-1:0]   rsp_event_res,
   output logic [smrp_pkg::ID_W-1:0]      rsp_out_servo_id,
   output logic [smrp_pkg::POS_W-1:0]     rsp_out_position,
   output logic [smrp_pkg::TICKS_W-1:0]   rsp_out_move_ticks,
   output logic [smrp_pkg::COUNT_W-1:0]   rsp_stored_count,
   output logic                           rsp_is_recording,
   output logic                           rsp_is_playing,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [smrp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [smrp_pkg::CSR_DATA_W-1:0] csr_data
);

   import smrp_pkg::*;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   result_type res;
   req_type    req;
   cfg_type    cfg_ff;
   logic       accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign req       = '{command: req_command, servo_id: req_servo_id,
                        target_position: req_target_position,
                        move_ticks: req_move_ticks};

   smrp_core u_core (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req),
      .cfg    (cfg_ff),
      .res    (res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff     <= 1'b0;
         cfg_ff.marker_id <= MARKER_RESET;
         cfg_ff.margin    <= MARGIN_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_idx_type'(csr_index))
               CSR_MARKER: cfg_ff.marker_id <= csr_data[ID_W-1:0];
               CSR_MARGIN: cfg_ff.margin    <= csr_data[MARGIN_W-1:0];
               default: begin
                  cfg_ff <= cfg_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_res      = rsp_ff.event_res;
   assign rsp_out_servo_id   = rsp_ff.servo_id;
   assign rsp_out_position   = rsp_ff.position;
   assign rsp_out_move_ticks = rsp_ff.move_ticks;
   assign rsp_stored_count   = rsp_ff.stored_count;
   assign rsp_is_recording   = rsp_ff.is_recording;
   assign rsp_is_playing     = rsp_ff.is_playing;

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// Testbench for the servo move record/playback sequencer
// Commands and ticks go in through the request channel from a queue of
// pending transactions. A predictor of the sequencer, kept in step at every
// accepted request, yields the expected result, and the monitor compares each
// accepted response against it. The settings registers are rewritten between
// phases once all responses are in. Both sides idle at random, and the
// receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import smrp_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned HOLD_AT        = 250;
   localparam int unsigned HOLD_CYCLES    = 300;
   localparam int unsigned END_TAIL       = 20;
   localparam int unsigned MAX_REPORTS    = 10;

   // Command codes the block leaves unused.
   localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
   } csr_write_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [CMD_W-1:0]      req_command = '0;
   logic [ID_W-1:0]       req_servo_id = '0;
   logic [POS_W-1:0]      req_target_position = '0;
   logic [TICKS_W-1:0]    req_move_ticks = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [EVENT_W-1:0]    rsp_event_res;
   logic [ID_W-1:0]       rsp_out_servo_id;
   logic [POS_W-1:0]      rsp_out_position;
   logic [TICKS_W-1:0]    rsp_out_move_ticks;
   logic [COUNT_W-1:0]    rsp_stored_count;
   logic                  rsp_is_recording;
   logic                  rsp_is_playing;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   always #5 clock = ~clock;

   servo_move_record_playback u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_command         (req_command),
      .req_servo_id        (req_servo_id),
      .req_target_position (req_target_position),
      .req_move_ticks      (req_move_ticks),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_event_res       (rsp_event_res),
      .rsp_out_servo_id    (rsp_out_servo_id),
      .rsp_out_position    (rsp_out_position),
      .rsp_out_move_ticks  (rsp_out_move_ticks),
      .rsp_stored_count    (rsp_stored_count),
      .rsp_is_recording    (rsp_is_recording),
      .rsp_is_playing      (rsp_is_playing),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   // Predicted sequencer state and settings.
   entry_type           seq_table [TABLE_DEPTH];
   logic [COUNT_W-1:0]  seq_count     = '0;
   logic                seq_recording = 1'b0;
   logic                seq_playing   = 1'b0;
   logic [COUNT_W-1:0]  seq_pointer   = '0;
   logic [WAIT_W-1:0]   seq_wait      = '0;
   logic [ID_W-1:0]     seq_marker    = MARKER_RESET;
   logic [MARGIN_W-1:0] seq_margin    = MARGIN_RESET;

   req_type       pending_items [$];
   result_type    predicted_results [$];
   csr_write_type csr_writes [$];

   int unsigned items_planned    = 0;
   int unsigned items_offered    = 0;
   int unsigned results_checked  = 0;
   int unsigned mismatches       = 0;
   int unsigned csr_pending      = 0;
   int unsigned settings_written = 0;
   int unsigned moves_issued     = 0;
   int unsigned resets_issued    = 0;
   int unsigned playbacks_done   = 0;
   int unsigned rejects_seen     = 0;
   int unsigned idle_cycles      = 0;
   bit          no_idle          = 1'b0;

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 60) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Applies one request to the predicted state and returns its response.
   function automatic result_type sequencer_step(input req_type item);
      result_type res;
      entry_type  ent;
      res = '0;
      case (item.command)
         CMD_TICK: begin
            if (seq_playing) begin
               if (seq_pointer >= seq_count) begin
                  seq_playing   = 1'b0;
                  res.event_res = EV_FINISHED;
               end else begin
                  if (seq_wait != 0) seq_wait = seq_wait - 1'b1;
                  if (seq_wait == 0) begin
                     ent            = seq_table[seq_pointer[ADDR_W-1:0]];
                     res.servo_id   = ent.id;
                     res.move_ticks = ent.ticks;
                     if (ent.id == seq_marker) begin
                        res.event_res = EV_RESET_ALL;
                     end else begin
                        res.event_res = EV_MOVE;
                        res.position  = ent.pos;
                     end
                     seq_wait    = ent.ticks + seq_margin;
                     seq_pointer = seq_pointer + 1'b1;
                  end
               end
            end
         end
         CMD_RECORD: begin
            if (seq_count >= TABLE_DEPTH) begin
               res.event_res = EV_REJECT;
            end else begin
               seq_table[seq_count[ADDR_W-1:0]] =
                  '{id: item.servo_id, pos: item.target_position, ticks: item.move_ticks};
               seq_count     = seq_count + 1'b1;
               res.event_res = EV_ACCEPT;
            end
         end
         CMD_CLEAR: begin
            seq_count     = '0;
            res.event_res = EV_ACCEPT;
         end
         CMD_START_REC: begin
            if (seq_playing || seq_recording) begin
               res.event_res = EV_REJECT;
            end else begin
               seq_count     = '0;
               seq_recording = 1'b1;
               res.event_res = EV_ACCEPT;
            end
         end
         CMD_STOP_REC: begin
            if (!seq_recording) begin
               res.event_res = EV_REJECT;
            end else begin
               seq_recording = 1'b0;
               res.event_res = EV_ACCEPT;
            end
         end
         CMD_PLAY: begin
            if (seq_recording || seq_playing || seq_count == 0) begin
               res.event_res = EV_REJECT;
            end else begin
               seq_playing   = 1'b1;
               seq_pointer   = '0;
               seq_wait      = '0;
               res.event_res = EV_ACCEPT;
            end
         end
         default: ;
      endcase
      res.stored_count = seq_count;
      res.is_recording = seq_recording;
      res.is_playing   = seq_playing;
      return res;
   endfunction

   // Request driver: one transaction at a time from the pending queue.
   always @(posedge clock) begin : req_driver
      req_type     offered;
      int unsigned req_gap;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            offered.command         = req_command;
            offered.servo_id        = req_servo_id;
            offered.target_position = req_target_position;
            offered.move_ticks      = req_move_ticks;
            predicted_results.push_back(sequencer_step(offered));
         end
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               offered = pending_items.pop_front();
               req_command         <= offered.command;
               req_servo_id        <= offered.servo_id;
               req_target_position <= offered.target_position;
               req_move_ticks      <= offered.move_ticks;
               req_valid           <= 1'b1;
               items_offered++;
               req_gap = pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Settings writes; the predictor takes the new value at acceptance.
   always @(posedge clock) begin : csr_driver
      csr_write_type wr;
      if (reset) begin
         csr_valid <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MARKER: seq_marker = csr_data[ID_W-1:0];
               CSR_MARGIN: seq_margin = csr_data[MARGIN_W-1:0];
               default: ;
            endcase
            csr_pending--;
         end
         if (!csr_valid || csr_ready) begin
            if (csr_writes.size() > 0) begin
               wr = csr_writes.pop_front();
               csr_index <= wr.idx;
               csr_data  <= wr.data;
               csr_valid <= 1'b1;
            end else begin
               csr_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and receiver back-pressure.
   always @(posedge clock) begin : rsp_monitor
      result_type  observed;
      result_type  wanted;
      int unsigned rsp_stall;
      int unsigned hold_left;
      bit          hold_done;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall = 0;
         hold_left = 0;
         hold_done = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            observed.event_res    = rsp_event_res;
            observed.servo_id     = rsp_out_servo_id;
            observed.position     = rsp_out_position;
            observed.move_ticks   = rsp_out_move_ticks;
            observed.stored_count = rsp_stored_count;
            observed.is_recording = rsp_is_recording;
            observed.is_playing   = rsp_is_playing;
            if (predicted_results.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: response with no request pending, event %0d",
                           $time, observed.event_res);
            end else begin
               wanted = predicted_results.pop_front();
               results_checked++;
               case (wanted.event_res)
                  EV_MOVE:      moves_issued++;
                  EV_RESET_ALL: resets_issued++;
                  EV_FINISHED:  playbacks_done++;
                  EV_REJECT:    rejects_seen++;
                  default: ;
               endcase
               if (observed !== wanted) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS) begin
                     $display("%0t: mismatch on response %0d", $time, results_checked);
                     $display("   expected ev=%0d id=%0d pos=%0d ticks=%0d cnt=%0d rec=%0b play=%0b",
                              wanted.event_res, wanted.servo_id, wanted.position,
                              wanted.move_ticks, wanted.stored_count,
                              wanted.is_recording, wanted.is_playing);
                     $display("   actual   ev=%0d id=%0d pos=%0d ticks=%0d cnt=%0d rec=%0b play=%0b",
                              observed.event_res, observed.servo_id, observed.position,
                              observed.move_ticks, observed.stored_count,
                              observed.is_recording, observed.is_playing);
                  end
               end
            end
         end
         // One long hold-off lets the sender back up against a full block.
         if (!hold_done && results_checked >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 99) < 30) rsp_stall = pick_gap();
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
         $display("tb_top: FAIL");
         $finish;
      end else begin
         idle_cycles++;
      end
   end

   task automatic add_item(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                           input logic [POS_W-1:0] pos, input logic [TICKS_W-1:0] ticks);
      req_type item;
      item = '{command: cmd, servo_id: id, target_position: pos, move_ticks: ticks};
      pending_items.push_back(item);
      items_planned++;
   endtask

   // Commands other than record ignore the payload, so it is left random.
   task automatic add_control(input logic [CMD_W-1:0] cmd);
      add_item(cmd, ID_W'($urandom()), POS_W'($urandom()), TICKS_W'($urandom()));
   endtask

   task automatic add_noise();
      add_control(CMD_W'($urandom_range(0, 7)));
   endtask

   function automatic logic [ID_W-1:0] pick_servo_id(input logic [ID_W-1:0] marker);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 25) return marker;
      if (roll < 35) return '0;
      if (roll < 45) return '1;
      return ID_W'($urandom());
   endfunction

   // A recording session followed by its playback, with enough ticks to
   // finish it when that fits in tick_cap. Playback that is cut short or
   // disturbed by stray commands is ended by a clear and a tick.
   task automatic plan_take(input logic [ID_W-1:0] marker, input int unsigned margin,
                            input int unsigned moves, input int unsigned tick_cap,
                            input bit long_moves);
      int unsigned need;
      int unsigned kept;
      int unsigned prev_wait;
      int unsigned dur;
      int unsigned n_ticks;
      bit          broken;
      bit          noisy;
      broken    = ($urandom_range(0, 9) == 0);
      noisy     = 1'b0;
      need      = 2;
      kept      = 0;
      prev_wait = 0;
      add_control(CMD_START_REC);
      for (int i = 0; i < moves; i++) begin
         if (long_moves && $urandom_range(0, 7) == 0) dur = $urandom_range(0, 65535);
         else dur = $urandom_range(0, 4);
         add_item(CMD_RECORD, pick_servo_id(marker), POS_W'($urandom()), TICKS_W'(dur));
         if (kept < TABLE_DEPTH) begin
            if (kept > 0) need += prev_wait;
            prev_wait = (dur + margin == 0) ? 1 : dur + margin;
            kept++;
         end
         if ($urandom_range(0, 19) == 0) begin
            add_noise();
            noisy = 1'b1;
         end
      end
      if (!broken) add_control(CMD_STOP_REC);
      add_control(CMD_PLAY);
      n_ticks = (need > tick_cap) ? tick_cap : need;
      for (int i = 0; i < n_ticks; i++) begin
         add_control(CMD_TICK);
         if ($urandom_range(0, 32) == 0) begin
            add_noise();
            noisy = 1'b1;
         end
      end
      if (broken) add_control(CMD_STOP_REC);
      if (noisy || need > tick_cap) begin
         add_control(CMD_CLEAR);
         add_control(CMD_TICK);
         add_control(CMD_STOP_REC);
      end
   endtask

   task automatic plan_phase(input logic [ID_W-1:0] marker, input int unsigned margin,
                             input int unsigned target, input int unsigned max_moves,
                             input int unsigned tick_cap, input bit long_moves,
                             input bit fill_table);
      int unsigned first;
      first = items_planned;
      if (fill_table) plan_take(marker, margin, $urandom_range(64, 67), tick_cap, 1'b0);
      while (items_planned - first < target)
         plan_take(marker, margin, $urandom_range(0, max_moves), tick_cap, long_moves);
   endtask

   task automatic drain();
      while (pending_items.size() != 0 || items_offered != results_checked)
         @(posedge clock);
   endtask

   task automatic write_settings(input logic [ID_W-1:0] marker,
                                 input logic [MARGIN_W-1:0] margin);
      drain();
      csr_writes.push_back('{idx: CSR_MARKER, data: CSR_DATA_W'(marker)});
      csr_writes.push_back('{idx: CSR_MARGIN, data: CSR_DATA_W'(margin)});
      csr_pending      += 2;
      settings_written += 2;
      while (csr_pending != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [ID_W-1:0]     marker_sel;
      logic [MARGIN_W-1:0] margin_sel;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Mode rules with the settings at their reset values.
      add_item(CMD_TICK, 0, 0, 0);
      add_item(CMD_STOP_REC, 0, 0, 0);
      add_item(CMD_PLAY, 0, 0, 0);
      add_item(CMD_RECORD, 8'd255, 12'd4095, 16'd65535);
      add_item(CMD_CLEAR, 0, 0, 0);
      add_item(CMD_START_REC, 0, 0, 0);
      add_item(CMD_START_REC, 0, 0, 0);
      add_item(CMD_PLAY, 0, 0, 0);
      add_item(CMD_RECORD, 8'd255, 12'd4095, 16'd65535);
      add_item(CMD_RECORD, 0, 0, 0);
      add_item(CMD_STOP_REC, 0, 0, 0);
      add_item(CMD_STOP_REC, 0, 0, 0);
      add_item(CMD_PLAY, 0, 0, 0);
      add_item(CMD_PLAY, 0, 0, 0);
      add_item(CMD_START_REC, 0, 0, 0);
      add_item(CMD_TICK, 0, 0, 0);
      // Clearing during playback ends it on the next tick.
      add_item(CMD_CLEAR, 0, 0, 0);
      add_item(CMD_TICK, 0, 0, 0);
      add_item(CMD_SPARE_6, 8'd255, 12'd4095, 16'd65535);
      add_item(CMD_SPARE_7, 0, 0, 0);

      // Marker zero, no margin: countdown edges and a record during playback.
      write_settings(8'd0, 10'd0);
      add_item(CMD_START_REC, 0, 0, 0);
      add_item(CMD_RECORD, 8'd0, 12'd4095, 16'd1);
      add_item(CMD_RECORD, 8'd255, 12'd4095, 16'd2);
      add_item(CMD_STOP_REC, 0, 0, 0);
      add_item(CMD_PLAY, 0, 0, 0);
      add_item(CMD_TICK, 0, 0, 0);
      add_item(CMD_TICK, 0, 0, 0);
      add_item(CMD_RECORD, 8'd17, 12'd100, 16'd0);
      add_item(CMD_TICK, 0, 0, 0);
      add_item(CMD_TICK, 0, 0, 0);
      add_item(CMD_TICK, 0, 0, 0);

      write_settings(MARKER_RESET, MARGIN_RESET);
      plan_phase(MARKER_RESET, MARGIN_RESET, 110, 4, 160, 1'b0, 1'b0);

      // No margin lets the full table play back in a modest number of ticks.
      marker_sel = ID_W'($urandom());
      write_settings(marker_sel, 10'd0);
      plan_phase(marker_sel, 0, 250, 6, 220, 1'b0, 1'b1);

      marker_sel = ID_W'($urandom());
      write_settings(marker_sel, 10'd1023);
      plan_phase(marker_sel, 1023, 80, 4, 30, 1'b1, 1'b0);

      marker_sel = ID_W'($urandom());
      margin_sel = MARGIN_W'($urandom_range(1, 7));
      write_settings(marker_sel, margin_sel);
      no_idle = 1'b1;
      plan_phase(marker_sel, margin_sel, 140, 6, 120, 1'b0, 1'b0);

      drain();
      no_idle = 1'b0;
      marker_sel = ID_W'($urandom());
      write_settings(marker_sel, 10'd2);
      plan_phase(marker_sel, 2, 120, 5, 100, 1'b1, 1'b0);

      drain();
      repeat (END_TAIL) @(posedge clock);

      $display("Covered %0d transactions under %0d settings writes: %0d moves,",
               results_checked, settings_written, moves_issued);
      $display("%0d reset-alls, %0d finished playbacks, %0d rejects; %0d mismatches.",
               resets_issued, playbacks_done, rejects_seen, mismatches);
      if (mismatches == 0 && predicted_results.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
